### rtl/ocp_pkg.sv
package ocp_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_slot;
    typedef logic [1:0] t_kw;

    localparam t_kind KIND_ADD       = 2'd0;
    localparam t_kind KIND_CANCEL    = 2'd1;
    localparam t_kind KIND_MALFORMED = 2'd2;

    localparam t_kw KW_ADD    = 2'd0;
    localparam t_kw KW_CANCEL = 2'd1;
    localparam t_kw KW_BUY    = 2'd2;
    localparam t_kw KW_SELL   = 2'd3;

    // captured field slots
    localparam t_slot SLOT_REQ    = 3'd0;
    localparam t_slot SLOT_ACCT   = 3'd1;
    localparam t_slot SLOT_PRICE  = 3'd2;
    localparam t_slot SLOT_QTY    = 3'd3;
    localparam t_slot SLOT_TARGET = 3'd4;
    localparam t_slot SLOT_NONE   = 3'd7;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] TOKENS_ADD    = 3'd6;
    localparam logic [2:0] TOKENS_CANCEL = 3'd4;
    localparam logic [2:0] POS_MAX       = 3'd7;
    localparam logic [4:0] LEN_MAX       = 5'd31;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        t_kind       command_kind;
        logic [63:0] request_number;
        logic [63:0] account_number;
        logic        order_side;
        logic [62:0] limit_price;
        logic [62:0] order_quantity;
        logic [63:0] cancel_target;
    } t_res_word;

    function automatic logic [4:0] kw_len(input t_kw k);
        logic [4:0] len;
        case (k)
            KW_ADD:    len = 5'd3;
            KW_CANCEL: len = 5'd6;
            KW_BUY:    len = 5'd3;
            KW_SELL:   len = 5'd4;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input t_kw k, input logic [2:0] idx);
        logic [47:0] txt;
        case (k)
            KW_ADD:    txt = {"ADD", 24'h0};
            KW_CANCEL: txt = "CANCEL";
            KW_BUY:    txt = {"BUY", 24'h0};
            KW_SELL:   txt = {"SELL", 16'h0};
            default:   txt = 48'h0;
        endcase
        case (idx)
            3'd0:    return txt[47:40];
            3'd1:    return txt[39:32];
            3'd2:    return txt[31:24];
            3'd3:    return txt[23:16];
            3'd4:    return txt[15:8];
            3'd5:    return txt[7:0];
            default: return 8'h0;
        endcase
    endfunction

    function automatic logic kw_hit(input logic [3:0] flags, input logic [4:0] len,
                                    input t_kw k);
        return flags[k] && (len == kw_len(k));
    endfunction

    function automatic t_slot number_slot(input logic [2:0] pos, input logic cancel);
        t_slot s;
        case (pos)
            3'd1:    s = SLOT_REQ;
            3'd2:    s = SLOT_ACCT;
            3'd3:    s = cancel ? SLOT_TARGET : SLOT_NONE;
            3'd4:    s = cancel ? SLOT_NONE : SLOT_PRICE;
            3'd5:    s = cancel ? SLOT_NONE : SLOT_QTY;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

### rtl/ocp_if.sv
interface ocp_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       line_end;

    modport source (output valid, output data_byte, output byte_valid, output line_end,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid, input line_end,
                  output ready);
endinterface

interface ocp_res_if;
    logic                valid;
    logic                ready;
    ocp_pkg::t_kind      command_kind;
    logic [63:0]         request_number;
    logic [63:0]         account_number;
    logic                order_side;
    logic [62:0]         limit_price;
    logic [62:0]         order_quantity;
    logic [63:0]         cancel_target;

    modport source (output valid, output command_kind, output request_number,
                    output account_number, output order_side, output limit_price,
                    output order_quantity, output cancel_target, input ready);
    modport sink (input valid, input command_kind, input request_number,
                  input account_number, input order_side, input limit_price,
                  input order_quantity, input cancel_target, output ready);
endinterface

### rtl/order_command_line_parser_top.sv
// Channel  Dir  Word                                   Accepted when
// i_cmd    in   data_byte, byte_valid, line_end        valid && ready
// o_res    out  command_kind .. cancel_target          valid && ready
//
// One byte per cycle while the input is not stalled: input register, parse logic, result register.
// A result becomes valid once the accepted line_end word has passed the input register and the result register.
// Synchronous active-low reset; the parser restarts at a line start.
// Only a line_end word waiting behind an untaken result stalls the input;
// other words keep flowing while a result waits.
module order_command_line_parser_top #(
    parameter int VALUE_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ocp_cmd_if.sink    i_cmd,
    ocp_res_if.source  o_res
);

    localparam int AW = VALUE_BITS + 4;
    localparam logic [AW-1:0] ID_LIM  = {4'b0, {VALUE_BITS{1'b1}}};
    localparam logic [AW-1:0] AMT_LIM = {5'b0, {(VALUE_BITS - 1){1'b1}}};

    logic                  r_in_vld;
    ocp_pkg::t_in_word     r_in;
    logic                  s_adv;

    logic [2:0]            r_pos,  n_pos;
    logic [4:0]            r_len,  n_len;
    logic [VALUE_BITS-1:0] r_acc,  n_acc;
    logic [3:0]            r_flags, n_flags;
    logic [VALUE_BITS-1:0] r_caps [5];
    logic [VALUE_BITS-1:0] n_caps [5];
    logic [1:0]            r_cs,   n_cs;
    logic                  r_err,  n_err;
    logic                  r_last, n_last;

    logic                  r_out_vld;
    ocp_pkg::t_res_word    r_res, n_res;

    assign s_adv       = r_in_vld && !(r_in.line_end && r_out_vld && !o_res.ready);
    assign i_cmd.ready = !r_in_vld || s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
        if (i_cmd.ready && i_cmd.valid) begin
            r_in <= '{data_byte: i_cmd.data_byte, byte_valid: i_cmd.byte_valid,
                      line_end: i_cmd.line_end};
        end
    end

    always_comb begin
        logic                  is_space;
        logic                  take;
        logic                  is_digit;
        logic                  cancel;
        logic                  last_a;
        logic                  fin;
        logic                  ok;
        ocp_pkg::t_slot        slot;
        logic [AW-1:0]         acc_ext;
        logic [AW-1:0]         prod;
        logic [AW-1:0]         lim;
        logic [3:0]            flags_t;
        logic [VALUE_BITS-1:0] acc_t;
        logic [4:0]            len_t;
        logic                  err_t;

        is_space = r_in.byte_valid && (r_in.data_byte == ocp_pkg::CHAR_SPACE);
        take     = r_in.byte_valid && !is_space;
        is_digit = (r_in.data_byte >= ocp_pkg::CHAR_ZERO) &&
                   (r_in.data_byte <= ocp_pkg::CHAR_NINE);
        cancel   = r_cs[0];
        slot     = ocp_pkg::number_slot(r_pos, cancel);
        acc_ext  = AW'(r_acc);
        prod     = (acc_ext << 3) + (acc_ext << 1) + AW'(r_in.data_byte[3:0]);
        lim      = (slot == ocp_pkg::SLOT_PRICE || slot == ocp_pkg::SLOT_QTY) ?
                   AMT_LIM : ID_LIM;

        flags_t = r_flags;
        acc_t   = r_acc;
        len_t   = r_len;
        err_t   = r_err;

        if (take) begin
            for (int k = 0; k < 4; k++) begin
                flags_t[k] = r_flags[k] && (r_len < ocp_pkg::kw_len(2'(k))) &&
                             (ocp_pkg::kw_char(2'(k), r_len[2:0]) == r_in.data_byte);
            end
            if (slot != ocp_pkg::SLOT_NONE) begin
                if (!is_digit || prod > lim) begin
                    err_t = 1'b1;
                end else begin
                    acc_t = prod[VALUE_BITS-1:0];
                end
            end
            if (r_len != ocp_pkg::LEN_MAX) begin
                len_t = r_len + 5'd1;
            end
        end

        if (is_space && r_last) begin
            err_t = 1'b1;
        end
        last_a = r_in.byte_valid ? is_space : r_last;
        fin    = (is_space && !r_last) || (r_in.line_end && !last_a);
        if (r_in.line_end && last_a) begin
            err_t = 1'b1;
        end

        n_pos   = r_pos;
        n_cs    = r_cs;
        n_caps  = r_caps;
        n_err   = err_t;
        n_flags = flags_t;
        n_acc   = acc_t;
        n_len   = len_t;

        if (fin) begin
            if (r_pos == 3'd0) begin
                if (ocp_pkg::kw_hit(flags_t, len_t, ocp_pkg::KW_ADD)) begin
                    n_cs = 2'b00;
                end else if (ocp_pkg::kw_hit(flags_t, len_t, ocp_pkg::KW_CANCEL)) begin
                    n_cs = 2'b01;
                end else begin
                    n_err = 1'b1;
                end
            end else if (r_pos == 3'd3 && !cancel) begin
                if (ocp_pkg::kw_hit(flags_t, len_t, ocp_pkg::KW_BUY)) begin
                    n_cs[1] = 1'b0;
                end else if (ocp_pkg::kw_hit(flags_t, len_t, ocp_pkg::KW_SELL)) begin
                    n_cs[1] = 1'b1;
                end else begin
                    n_err = 1'b1;
                end
            end else if (slot != ocp_pkg::SLOT_NONE) begin
                if (acc_t == '0) begin
                    n_err = 1'b1;
                end
                n_caps[slot] = acc_t;
            end
            if (r_pos != ocp_pkg::POS_MAX) begin
                n_pos = r_pos + 3'd1;
            end
            n_len   = '0;
            n_acc   = '0;
            n_flags = '1;
        end

        ok = !n_err && (n_pos == (n_cs[0] ? ocp_pkg::TOKENS_CANCEL : ocp_pkg::TOKENS_ADD));

        n_res = '0;
        if (!ok) begin
            n_res.command_kind = ocp_pkg::KIND_MALFORMED;
        end else begin
            n_res.command_kind   = n_cs[0] ? ocp_pkg::KIND_CANCEL : ocp_pkg::KIND_ADD;
            n_res.request_number = 64'(n_caps[ocp_pkg::SLOT_REQ]);
            n_res.account_number = 64'(n_caps[ocp_pkg::SLOT_ACCT]);
            if (n_cs[0]) begin
                n_res.cancel_target = 64'(n_caps[ocp_pkg::SLOT_TARGET]);
            end else begin
                n_res.order_side     = n_cs[1];
                n_res.limit_price    = 63'(64'(n_caps[ocp_pkg::SLOT_PRICE]));
                n_res.order_quantity = 63'(64'(n_caps[ocp_pkg::SLOT_QTY]));
            end
        end

        n_last = last_a;
        if (r_in.line_end) begin
            n_pos   = '0;
            n_len   = '0;
            n_acc   = '0;
            n_flags = '1;
            for (int j = 0; j < 5; j++) begin
                n_caps[j] = '0;
            end
            n_cs    = '0;
            n_err   = 1'b0;
            n_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_flags <= '1;
            for (int j = 0; j < 5; j++) begin
                r_caps[j] <= '0;
            end
            r_cs    <= '0;
            r_err   <= 1'b0;
            r_last  <= 1'b1;
        end else if (s_adv) begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_flags <= n_flags;
            r_caps  <= n_caps;
            r_cs    <= n_cs;
            r_err   <= n_err;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_adv && r_in.line_end) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
        if (s_adv && r_in.line_end) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.command_kind   = r_res.command_kind;
    assign o_res.request_number = r_res.request_number;
    assign o_res.account_number = r_res.account_number;
    assign o_res.order_side     = r_res.order_side;
    assign o_res.limit_price    = r_res.limit_price;
    assign o_res.order_quantity = r_res.order_quantity;
    assign o_res.cancel_target  = r_res.cancel_target;

endmodule

### sim/order_command_line_parser_top_tb.sv
`timescale 1ns / 1ps

module order_command_line_parser_top_tb;

    localparam int VALUE_BITS = 64;
    localparam logic [63:0] ID_MAX  = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] AMT_MAX = {64{1'b1}} >> (65 - VALUE_BITS);
    localparam int TOTAL_WORDS = 1650;
    localparam int TAIL_CYCLES = 8;
    localparam longint CYCLE_LIMIT = 300000;

    localparam logic [2:0] POS_CMD   = 3'd0;
    localparam logic [2:0] POS_REQ   = 3'd1;
    localparam logic [2:0] POS_ACCT  = 3'd2;
    localparam logic [2:0] POS_SIDE  = 3'd3;
    localparam logic [2:0] POS_PRICE = 3'd4;
    localparam logic [2:0] POS_QTY   = 3'd5;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_HOLD} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #2 i_clk = ~i_clk;

    ocp_cmd_if cmd_bus ();
    ocp_res_if res_bus ();

    order_command_line_parser_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // parser state as seen by the checker
    logic [2:0]  tok_idx;
    logic [4:0]  tok_len;
    logic [63:0] num_val;
    logic [3:0]  kw_live;
    logic [63:0] field_val [5];
    logic [1:0]  cmd_bits;
    logic        line_bad;
    logic        after_space;

    string keyword_text [4] = '{"ADD", "CANCEL", "BUY", "SELL"};
    string bad_words [10] = '{"AD", "ADDD", "add", "CANCE", "CANCELL",
                              "BUYY", "BU", "SEL", "SELLS", "Sell"};

    ocp_pkg::t_in_word  line_words [$];
    ocp_pkg::t_res_word predicted_commands [$];

    int       error_count = 0;
    int       words_total = 0;
    int       words_accepted = 0;
    int       live_words = 0;
    longint   cycle_count = 0;
    logic     cmd_taken = 1'b0;
    int       gap_left = 0;
    int       burst_left = 1;
    t_rx_mode stall_mode = RX_OPEN;
    int       stall_timer = 0;

    function automatic void start_token();
        tok_len = '0;
        num_val = '0;
        kw_live = 4'hF;
    endfunction

    function automatic void start_line();
        tok_idx = POS_CMD;
        start_token();
        for (int i = 0; i < 5; i++) field_val[i] = '0;
        cmd_bits = 2'b00;
        line_bad = 1'b0;
        after_space = 1'b1;
    endfunction

    function automatic ocp_pkg::t_slot field_slot(logic [2:0] idx, logic is_cancel);
        case (idx)
            POS_REQ:   return ocp_pkg::SLOT_REQ;
            POS_ACCT:  return ocp_pkg::SLOT_ACCT;
            POS_SIDE:  return is_cancel ? ocp_pkg::SLOT_TARGET : ocp_pkg::SLOT_NONE;
            POS_PRICE: return is_cancel ? ocp_pkg::SLOT_NONE : ocp_pkg::SLOT_PRICE;
            POS_QTY:   return is_cancel ? ocp_pkg::SLOT_NONE : ocp_pkg::SLOT_QTY;
            default:   return ocp_pkg::SLOT_NONE;
        endcase
    endfunction

    function automatic logic keyword_done(ocp_pkg::t_kw k);
        return kw_live[k] && (tok_len == keyword_text[k].len());
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        logic [3:0]     hits;
        logic [63:0]    lim;
        logic [63:0]    d;
        ocp_pkg::t_slot slot;
        hits = '0;
        for (int k = 0; k < 4; k++) begin
            if (kw_live[k] && tok_len < keyword_text[k].len() &&
                    keyword_text[k].getc(tok_len) == c) begin
                hits[k] = 1'b1;
            end
        end
        kw_live = hits;
        if (tok_idx != POS_CMD) begin
            slot = field_slot(tok_idx, cmd_bits[0]);
            if (slot != ocp_pkg::SLOT_NONE) begin
                lim = (slot == ocp_pkg::SLOT_PRICE || slot == ocp_pkg::SLOT_QTY) ?
                      AMT_MAX : ID_MAX;
                if (c < ocp_pkg::CHAR_ZERO || c > ocp_pkg::CHAR_NINE) begin
                    line_bad = 1'b1;
                end else begin
                    d = {56'd0, c - ocp_pkg::CHAR_ZERO};
                    if (num_val > (lim - d) / 10) line_bad = 1'b1;
                    else num_val = num_val * 10 + d;
                end
            end
        end
        if (tok_len < ocp_pkg::LEN_MAX) tok_len++;
    endfunction

    function automatic void close_token();
        ocp_pkg::t_slot slot;
        slot = field_slot(tok_idx, cmd_bits[0]);
        if (tok_idx == POS_CMD) begin
            if (keyword_done(ocp_pkg::KW_ADD)) cmd_bits = 2'b00;
            else if (keyword_done(ocp_pkg::KW_CANCEL)) cmd_bits = 2'b01;
            else line_bad = 1'b1;
        end else if (tok_idx == POS_SIDE && !cmd_bits[0]) begin
            if (keyword_done(ocp_pkg::KW_BUY)) cmd_bits[1] = 1'b0;
            else if (keyword_done(ocp_pkg::KW_SELL)) cmd_bits[1] = 1'b1;
            else line_bad = 1'b1;
        end else if (slot != ocp_pkg::SLOT_NONE) begin
            if (num_val == 0) line_bad = 1'b1;
            field_val[slot] = num_val;
        end
        if (tok_idx < ocp_pkg::POS_MAX) tok_idx++;
        start_token();
    endfunction

    function automatic void parse_word(ocp_pkg::t_in_word w);
        ocp_pkg::t_res_word r;
        logic               is_cancel;
        logic               ok;
        if (w.byte_valid) begin
            if (w.data_byte == ocp_pkg::CHAR_SPACE) begin
                if (after_space) line_bad = 1'b1;
                else close_token();
                after_space = 1'b1;
            end else begin
                after_space = 1'b0;
                absorb_char(w.data_byte);
            end
        end
        if (w.line_end) begin
            if (after_space) line_bad = 1'b1;
            else close_token();
            is_cancel = cmd_bits[0];
            ok = !line_bad &&
                 tok_idx == (is_cancel ? ocp_pkg::TOKENS_CANCEL : ocp_pkg::TOKENS_ADD);
            r = '0;
            if (!ok) begin
                r.command_kind = ocp_pkg::KIND_MALFORMED;
            end else if (is_cancel) begin
                r.command_kind   = ocp_pkg::KIND_CANCEL;
                r.request_number = field_val[ocp_pkg::SLOT_REQ];
                r.account_number = field_val[ocp_pkg::SLOT_ACCT];
                r.cancel_target  = field_val[ocp_pkg::SLOT_TARGET];
            end else begin
                r.command_kind   = ocp_pkg::KIND_ADD;
                r.request_number = field_val[ocp_pkg::SLOT_REQ];
                r.account_number = field_val[ocp_pkg::SLOT_ACCT];
                r.order_side     = cmd_bits[1];
                r.limit_price    = field_val[ocp_pkg::SLOT_PRICE][62:0];
                r.order_quantity = field_val[ocp_pkg::SLOT_QTY][62:0];
            end
            predicted_commands.insert(predicted_commands.size(), r);
            start_line();
        end
    endfunction

    function automatic void push_word(logic [7:0] c, logic v, logic e);
        ocp_pkg::t_in_word w;
        if ($urandom_range(0, 31) == 0) begin
            w.data_byte  = 8'($urandom);
            w.byte_valid = 1'b0;
            w.line_end   = 1'b0;
            line_words.insert(line_words.size(), w);
        end
        w.data_byte  = c;
        w.byte_valid = v;
        w.line_end   = e;
        line_words.insert(line_words.size(), w);
        live_words++;
    endfunction

    // marker = 1 closes the line with an empty end word
    function automatic void queue_line(string s, bit marker);
        for (int k = 0; k < s.len(); k++) begin
            push_word(s.getc(k), 1'b1, !marker && k == s.len() - 1);
        end
        if (marker || s.len() == 0) push_word(8'($urandom), 1'b0, 1'b1);
    endfunction

    function automatic string num_text(bit amount, bit allow_bad);
        logic [63:0]  lim;
        logic [63:0]  v;
        string        s;
        int           m;
        byte unsigned c;
        lim = amount ? AMT_MAX : ID_MAX;
        m = $urandom_range(0, 99);
        if (m < 60) v = 64'($urandom_range(1, 99999));
        else if (m < 70) v = {$urandom, $urandom} & lim;
        else if (m < 76) v = lim;
        else if (m < 80) v = lim - 64'($urandom_range(1, 20));
        else v = 64'($urandom_range(1, 9));
        if (v == 0) v = 1;
        s = $sformatf("%0d", v);
        if (m >= 80) begin
            repeat ((m >= 93) ? $urandom_range(28, 36) : $urandom_range(1, 3)) s = {"0", s};
        end
        if (allow_bad && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 4))
                0: s = ($urandom_range(0, 1) != 0) ? "0" : "000";
                1: begin
                    // one past the field maximum
                    s = $sformatf("%0d", lim);
                    s.putc(s.len() - 1, byte'(s.getc(s.len() - 1) + 1));
                end
                2: s = {$sformatf("%0d", lim), "0"};
                3: begin
                    do c = byte'($urandom_range(1, 255));
                    while (c == ocp_pkg::CHAR_SPACE ||
                           (c >= ocp_pkg::CHAR_ZERO && c <= ocp_pkg::CHAR_NINE));
                    s.putc($urandom_range(0, s.len() - 1), c);
                end
                default: s = {($urandom_range(0, 1) != 0) ? "+" : "-", s};
            endcase
        end
        return s;
    endfunction

    function automatic void queue_random_line();
        string        toks [$];
        string        s;
        string        pad;
        int           m;
        int           n;
        int           dbl;
        bit           lead;
        bit           trail;
        bit           is_add;
        bit           bad_nums;
        bit           on_byte;
        int           r;
        logic [7:0]   c;
        m = $urandom_range(0, 99);
        on_byte = $urandom_range(0, 1);
        if (m >= 90) begin
            // noise line: spaces, digits and arbitrary bytes
            n = $urandom_range(0, 30);
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 9);
                if (r < 3) c = ocp_pkg::CHAR_SPACE;
                else if (r < 6) c = ocp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
                else c = 8'($urandom_range(0, 255));
                push_word(c, 1'b1, on_byte && k == n - 1);
            end
            if (n == 0 || !on_byte) push_word(8'($urandom), 1'b0, 1'b1);
            return;
        end
        is_add = $urandom_range(0, 1);
        bad_nums = ($urandom_range(0, 3) == 0);
        if (is_add) begin
            toks.insert(toks.size(), "ADD");
            toks.insert(toks.size(), num_text(0, bad_nums));
            toks.insert(toks.size(), num_text(0, bad_nums));
            toks.insert(toks.size(), ($urandom_range(0, 1) != 0) ? "SELL" : "BUY");
            toks.insert(toks.size(), num_text(1, bad_nums));
            toks.insert(toks.size(), num_text(1, bad_nums));
        end else begin
            toks.insert(toks.size(), "CANCEL");
            repeat (3) toks.insert(toks.size(), num_text(0, bad_nums));
        end
        lead = 0;
        trail = 0;
        dbl = -1;
        if (m >= 70) begin
            case ($urandom_range(0, 7))
                0: lead = 1;
                1: trail = 1;
                2: dbl = $urandom_range(1, toks.size() - 1);
                3: toks.delete($urandom_range(0, toks.size() - 1));
                4: repeat ($urandom_range(1, 4)) toks.insert(toks.size(), num_text(0, 0));
                5: toks[(is_add && $urandom_range(0, 1) != 0) ? 3 : 0] =
                       bad_words[$urandom_range(0, 9)];
                6: toks[0] = is_add ? "CANCEL" : "ADD";
                default: begin
                    pad = "";
                    repeat ($urandom_range(26, 34)) pad = {pad, "D"};
                    toks[0] = {toks[0], pad};
                end
            endcase
        end
        s = lead ? " " : "";
        foreach (toks[i]) begin
            if (i != 0) s = {s, (i == dbl) ? "  " : " "};
            s = {s, toks[i]};
        end
        if (trail) s = {s, " "};
        queue_line(s, !on_byte);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        ocp_pkg::t_in_word nxt;
        if (i_rst_n && (cmd_taken || !cmd_bus.valid)) begin
            if (gap_left > 0 || line_words.size() == 0) begin
                if (gap_left > 0) gap_left--;
                cmd_bus.valid <= 1'b0;
            end else begin
                nxt = line_words.pop_front();
                cmd_bus.valid      <= 1'b1;
                cmd_bus.data_byte  <= nxt.data_byte;
                cmd_bus.byte_valid <= nxt.byte_valid;
                cmd_bus.line_end   <= nxt.line_end;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // result receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode = t_rx_mode'($urandom_range(0, 3));
            stall_timer = $urandom_range(8, 80);
        end else begin
            stall_timer--;
        end
        case (stall_mode)
            RX_OPEN:   res_bus.ready <= 1'b1;
            RX_MOSTLY: res_bus.ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: res_bus.ready <= ($urandom_range(0, 3) == 0);
            default:   res_bus.ready <= (stall_timer < 4);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        ocp_pkg::t_in_word  got_word;
        ocp_pkg::t_res_word want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (predicted_commands.size() == 0) begin
                    $error("result word with none expected, command_kind %0d",
                           res_bus.command_kind);
                    error_count++;
                end else begin
                    want = predicted_commands.pop_front();
                    check_field("command_kind", want.command_kind, res_bus.command_kind);
                    check_field("request_number", want.request_number,
                                res_bus.request_number);
                    check_field("account_number", want.account_number,
                                res_bus.account_number);
                    check_field("order_side", want.order_side, res_bus.order_side);
                    check_field("limit_price", want.limit_price, res_bus.limit_price);
                    check_field("order_quantity", want.order_quantity,
                                res_bus.order_quantity);
                    check_field("cancel_target", want.cancel_target, res_bus.cancel_target);
                end
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                got_word.data_byte  = cmd_bus.data_byte;
                got_word.byte_valid = cmd_bus.byte_valid;
                got_word.line_end   = cmd_bus.line_end;
                parse_word(got_word);
                words_accepted++;
            end
            cmd_taken <= cmd_bus.valid && cmd_bus.ready;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        ocp_pkg::t_in_word w;
        string             id_max_s;
        string             amt_max_s;
        string             id_over_s;
        string             amt_over_s;
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.data_byte  = '0;
        cmd_bus.byte_valid = 1'b0;
        cmd_bus.line_end   = 1'b0;
        res_bus.ready      = 1'b0;
        start_line();

        id_max_s = $sformatf("%0d", ID_MAX);
        amt_max_s = $sformatf("%0d", AMT_MAX);
        id_over_s = id_max_s;
        id_over_s.putc(id_over_s.len() - 1, byte'(id_over_s.getc(id_over_s.len() - 1) + 1));
        amt_over_s = amt_max_s;
        amt_over_s.putc(amt_over_s.len() - 1,
                        byte'(amt_over_s.getc(amt_over_s.len() - 1) + 1));

        // ignored word, then an empty line
        w.data_byte  = 8'hFF;
        w.byte_valid = 1'b0;
        w.line_end   = 1'b0;
        line_words.insert(line_words.size(), w);
        queue_line("", 1);
        queue_line(" ", 0);
        queue_line("ADD 1 1 BUY 1 1", 0);
        queue_line("CANCEL 1 1 1", 1);
        queue_line({"ADD ", id_max_s, " ", id_max_s, " SELL ", amt_max_s, " ", amt_max_s}, 0);
        queue_line({"CANCEL ", id_max_s, " ", id_max_s, " ", id_max_s}, 1);
        queue_line(" CANCEL 1 2 3", 0);
        queue_line("CANCEL 1 2 3 ", 0);
        queue_line("CANCEL 1  2 3", 1);
        queue_line("ADD 1 2 BUY 0 4", 0);
        queue_line({"ADD 1 2 SELL ", amt_over_s, " 4"}, 0);
        queue_line({"CANCEL ", id_over_s, " 2 3"}, 0);
        queue_line("CANCEL +1 2 3", 0);
        queue_line("ADD 1 2 BUY 3 -4", 1);
        queue_line("ADD 1 2 HOLD 3 4", 0);
        queue_line("MODIFY 1 2 3", 0);
        queue_line("CANCEL 1 2", 0);
        queue_line("ADD 1 2 BUY 3 4 5 6 7 8", 0);
        queue_line("CANCEL 000000000000000000000000000000000000007 2 3", 0);

        while (live_words < TOTAL_WORDS) queue_random_line();
        words_total = line_words.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted != words_total || predicted_commands.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ocp_pkg.sv
rtl/ocp_if.sv
rtl/order_command_line_parser_top.sv
sim/order_command_line_parser_top_tb.sv
